>>> src/jlvf_pkg.sv
`default_nettype none

package jlvf_pkg;

    // field and datapath widths
    localparam int DW  = 32;   // velocity, acceleration, jerk
    localparam int TSW = 16;   // time step, unsigned Q0.16
    localparam int AW  = 64;   // serial unit operand a (multiplicand, dividend, radicand)
    localparam int BW  = 32;   // serial unit operand b (multiplier, divisor)
    localparam int PW  = 66;   // serial unit result (product, quotient, root)
    localparam int CW  = 7;    // serial unit step count

    // register indexes on the configuration port
    localparam logic [1:0] REG_VMIN = 2'd0;
    localparam logic [1:0] REG_VMAX = 2'd1;
    localparam logic [1:0] REG_ALIM = 2'd2;
    localparam logic [1:0] REG_JLIM = 2'd3;

    typedef enum logic [1:0] {
        OP_MUL,
        OP_DIV,
        OP_SQRT
    } serial_op_t;

    typedef struct packed {
        logic             start;
        serial_op_t       op;
        logic [AW-1:0]    opa;
        logic [BW-1:0]    opb;
        logic [CW-1:0]    nbits;
    } serial_cmd_t;

    typedef struct packed {
        logic             done;
        logic [PW-1:0]    res;
    } serial_rsp_t;

endpackage

`default_nettype wire

>>> src/jerk_limited_velocity_filter.sv
// jerk-limited velocity filter, signed Q16.16 data, unsigned Q0.16 time step
//
// input channel (s_*): one transfer per step; mode 1 loads velocity and
// acceleration and clears jerk, mode 0 advances by s_time_step toward the
// clamped target (a zero time step just repeats the current state)
// result channel (m_*): exactly one transfer per input transfer, in order
// apb port: velocity_min at 0x0, velocity_max at 0x4, accel_limit at 0x8,
// jerk_limit at 0xc; write only while the block is idle; pready always high
//
// one item at a time: every multiply, divide and root goes through one shared serial unit
// (1 bit per cycle multiply and divide, 2 bits per cycle square root)
// input transfer to m_valid: a load or a hold goes straight to the done state
// trapezoid mode (jerk_limit 0): a 16-step multiply, then two 50-step divides
// jerk mode: two multiplies and a divide when snapping to target, else seven
// multiplies, a square root and two divides; the root is skipped when the radicand overflows
// s_ready is high only while idle, so the next transfer is taken in the cycle
// after the previous result is registered; a finished result waits in the
// output register for m_ready while the next step runs; a step that
// finishes while the previous result is still stalled waits for it
// reset (synchronous, active low) clears state and restores register defaults
`default_nettype none

module jerk_limited_velocity_filter (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    // configuration
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [3:0]         paddr,
    input  wire logic [31:0]        pwdata,
    output logic [31:0]             prdata,
    output logic                    pready,
    // input channel
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire logic               s_mode,
    input  wire logic signed [31:0] s_target_velocity,
    input  wire logic [15:0]        s_time_step,
    input  wire logic signed [31:0] s_load_velocity,
    input  wire logic signed [31:0] s_load_accel,
    // result channel
    output logic                    m_valid,
    input  wire logic               m_ready,
    output logic signed [31:0]      m_velocity,
    output logic signed [31:0]      m_acceleration,
    output logic signed [31:0]      m_jerk
);

    localparam logic [jlvf_pkg::CW-1:0] N_DT   = 7'd16;
    localparam logic [jlvf_pkg::CW-1:0] N_X    = 7'd30;
    localparam logic [jlvf_pkg::CW-1:0] N_J    = 7'd31;
    localparam logic [jlvf_pkg::CW-1:0] N_DIV  = 7'd50;
    localparam logic [jlvf_pkg::CW-1:0] N_SQRT = 7'd32;

    localparam logic signed [35:0] S36_MAX = 36'sh0_7FFF_FFFF;
    localparam logic signed [35:0] S36_MIN = -36'sh0_8000_0000;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_TMUL,
        ST_TDIV,
        ST_JMUL1,
        ST_JMUL2,
        ST_CMUL,
        ST_XMUL,
        ST_PMUL,
        ST_SQRT,
        ST_JDIV,
        ST_AMUL,
        ST_VMUL,
        ST_LDIV,
        ST_DONE
    } state_t;

    function automatic logic signed [31:0] sat32(input logic signed [35:0] x);
        if (x > S36_MAX) return 32'sh7FFF_FFFF;
        if (x < S36_MIN) return 32'sh8000_0000;
        return 32'(x);
    endfunction

    // quotient magnitude back to a signed, saturated value
    function automatic logic signed [31:0] persat(input logic neg,
                                                  input logic [jlvf_pkg::PW-1:0] q);
        logic [31:0] low;
        low = q[31:0];
        if (!neg) return (q > 66'h7FFF_FFFF) ? 32'sh7FFF_FFFF : $signed(low);
        return (q > 66'h8000_0000) ? 32'sh8000_0000 : $signed(-low);
    endfunction

    function automatic logic [33:0] mag36(input logic signed [35:0] x);
        logic signed [35:0] t;
        t = x[35] ? -x : x;
        return t[33:0];
    endfunction

    function automatic jlvf_pkg::serial_cmd_t mul_cmd(input logic [jlvf_pkg::AW-1:0] a,
                                                      input logic [jlvf_pkg::BW-1:0] b,
                                                      input logic [jlvf_pkg::CW-1:0] n);
        jlvf_pkg::serial_cmd_t c;
        c.start = 1'b1;
        c.op    = jlvf_pkg::OP_MUL;
        c.opa   = a;
        c.opb   = b;
        c.nbits = n;
        return c;
    endfunction

    // dividend is mag * 2^16, fed msb first
    function automatic jlvf_pkg::serial_cmd_t div_cmd(input logic [33:0] mag,
                                                      input logic [15:0] dt);
        jlvf_pkg::serial_cmd_t c;
        c.start = 1'b1;
        c.op    = jlvf_pkg::OP_DIV;
        c.opa   = {mag, 30'b0};
        c.opb   = jlvf_pkg::BW'(dt);
        c.nbits = N_DIV;
        return c;
    endfunction

    function automatic jlvf_pkg::serial_cmd_t sqrt_cmd(input logic [jlvf_pkg::AW-1:0] rad);
        jlvf_pkg::serial_cmd_t c;
        c.start = 1'b1;
        c.op    = jlvf_pkg::OP_SQRT;
        c.opa   = rad;
        c.opb   = '0;
        c.nbits = N_SQRT;
        return c;
    endfunction

    // registers
    state_t                  state_reg;
    logic signed [31:0]      vmin_reg;
    logic signed [31:0]      vmax_reg;
    logic [30:0]             alim_reg;
    logic [30:0]             jlim_reg;
    logic signed [31:0]      vel_reg;
    logic signed [31:0]      acc_reg;
    logic signed [31:0]      jrk_reg;
    logic signed [31:0]      vr_reg;
    logic [15:0]             dt_reg;
    logic [46:0]             p1_reg;
    logic                    cneg_reg;
    logic [33:0]             cmag_reg;
    logic [59:0]             x2_reg;
    logic                    dneg_reg;
    logic                    jneg_reg;
    logic                    sneg_reg;
    logic signed [31:0]      vnew_reg;
    logic signed [31:0]      anew_reg;
    jlvf_pkg::serial_cmd_t   cmd_reg;
    logic                    m_valid_reg;
    logic signed [31:0]      m_vel_reg;
    logic signed [31:0]      m_acc_reg;
    logic signed [31:0]      m_jrk_reg;

    jlvf_pkg::serial_rsp_t   srsp;

    jlvf_serial u_serial (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cmd     (cmd_reg),
        .rsp     (srsp)
    );

    // combinational step math
    logic                    cfg_wr;
    logic [30:0]             amax;
    logic signed [31:0]      vr_in;
    logic [jlvf_pkg::PW-1:0] res;
    logic signed [31:0]      q_sat;
    logic signed [35:0]      diff_vr;
    logic signed [35:0]      lim_s;
    logic signed [35:0]      dv;
    logic signed [31:0]      vsum_t;
    logic signed [35:0]      tdiff;
    logic signed [35:0]      ndiff;
    logic [33:0]             dmag;
    logic [33:0]             amag_now;
    logic [30:0]             jd;
    logic                    snap;
    logic signed [48:0]      cprod;
    logic signed [35:0]      cval;
    logic [29:0]             xval;
    logic [63:0]             rlim;
    logic                    ovf;
    logic [63:0]             rad;
    logic [33:0]             amag_star;
    logic signed [35:0]      astar;
    logic signed [35:0]      jdiff;
    logic [30:0]             jm;
    logic signed [47:0]      jprod;
    logic signed [35:0]      a1;
    logic signed [35:0]      amax_s;
    logic signed [35:0]      jd_s;
    logic signed [31:0]      a1_sat;
    logic signed [35:0]      asum;
    logic signed [49:0]      vprod;
    logic signed [31:0]      vnext_t;
    logic signed [35:0]      ldiff;

    always_comb begin
        cfg_wr = psel && penable && pwrite;
        amax   = (alim_reg == '0) ? 31'd1 : alim_reg;

        // target clamp: raise to min first, then lower to max
        vr_in = (s_target_velocity < vmin_reg) ? vmin_reg : s_target_velocity;
        vr_in = (vr_in > vmax_reg) ? vmax_reg : vr_in;

        res     = srsp.res;
        q_sat   = persat(dneg_reg, res);
        diff_vr = 36'(vr_reg) - 36'(vel_reg);

        // trapezoid step
        lim_s = $signed(36'(res[46:16]));
        dv    = diff_vr;
        if (dv < -lim_s) dv = -lim_s;
        if (dv > lim_s) dv = lim_s;
        vsum_t = sat32(36'(vel_reg) + dv);
        tdiff  = 36'(q_sat) - 36'(acc_reg);
        ndiff  = 36'sd0 - 36'(acc_reg);

        // snap test
        dmag     = mag36(diff_vr);
        amag_now = mag36(36'(acc_reg));
        jd       = p1_reg[46:16];
        snap     = (dmag <= 34'(res[62:32])) && (amag_now <= 34'(jd));

        // c = vr - v - floor(a*dt / 2^17)
        cprod = $signed({1'b0, res[47:0]});
        if (acc_reg[31]) cprod = -cprod;
        cval = diff_vr - 36'(cprod >>> 17);
        xval = p1_reg[46:17];

        // radicand X^2 + 2|c|J, with a cap when it leaves 64 bits
        rlim = (~{4'b0, x2_reg}) >> 1;
        ovf  = res[64:0] > {1'b0, rlim};
        rad  = {4'b0, x2_reg} + {res[62:0], 1'b0};

        if (state_reg == ST_SQRT) amag_star = 34'(res[31:0]) - 34'(xval);
        else amag_star = 34'h2_0000_0000;
        astar = $signed(36'(amag_star));
        if (cneg_reg) astar = -astar;
        jdiff = astar - 36'(acc_reg);

        // jerk clamp on the quotient magnitude
        jm = (res > jlvf_pkg::PW'(jlim_reg)) ? jlim_reg : res[30:0];

        // new acceleration
        jprod = $signed({1'b0, res[46:0]});
        if (jneg_reg) jprod = -jprod;
        a1     = 36'(acc_reg) + 36'(jprod >>> 16);
        amax_s = $signed(36'(amax));
        jd_s   = $signed(36'(jd));
        if (a1 < -amax_s) a1 = -amax_s;
        if (a1 > amax_s) a1 = amax_s;
        if (a1 < 36'(acc_reg) - jd_s) a1 = 36'(acc_reg) - jd_s;
        if (a1 > 36'(acc_reg) + jd_s) a1 = 36'(acc_reg) + jd_s;
        a1_sat = sat32(a1);
        asum   = 36'(acc_reg) + 36'(a1_sat);

        // jerk-mode velocity update from the sum of old and new acceleration
        vprod = $signed({1'b0, res[48:0]});
        if (sneg_reg) vprod = -vprod;
        vnext_t = sat32(36'(vel_reg) + 36'(vprod >>> 17));
        ldiff   = 36'(anew_reg) - 36'(acc_reg);

        case (paddr[3:2])
            jlvf_pkg::REG_VMIN: prdata = vmin_reg;
            jlvf_pkg::REG_VMAX: prdata = vmax_reg;
            jlvf_pkg::REG_ALIM: prdata = {1'b0, alim_reg};
            jlvf_pkg::REG_JLIM: prdata = {1'b0, jlim_reg};
            default:            prdata = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            m_valid_reg   <= 1'b0;
            cmd_reg.start <= 1'b0;
            vmin_reg      <= -32'sd65536;
            vmax_reg      <= 32'sd65536;
            alim_reg      <= 31'd65536;
            jlim_reg      <= 31'd65536;
            vel_reg       <= '0;
            acc_reg       <= '0;
            jrk_reg       <= '0;
        end else begin
            cmd_reg.start <= 1'b0;
            if (m_valid_reg && m_ready) m_valid_reg <= 1'b0;

            if (cfg_wr) begin
                case (paddr[3:2])
                    jlvf_pkg::REG_VMIN: vmin_reg <= pwdata;
                    jlvf_pkg::REG_VMAX: vmax_reg <= pwdata;
                    jlvf_pkg::REG_ALIM: alim_reg <= pwdata[30:0];
                    jlvf_pkg::REG_JLIM: jlim_reg <= pwdata[30:0];
                    default:            alim_reg <= alim_reg;
                endcase
            end

            case (state_reg)
                ST_IDLE: begin
                    if (s_valid) begin
                        dt_reg <= s_time_step;
                        vr_reg <= vr_in;
                        if (s_mode) begin
                            vel_reg   <= s_load_velocity;
                            acc_reg   <= s_load_accel;
                            jrk_reg   <= '0;
                            state_reg <= ST_DONE;
                        end else if (s_time_step == '0) begin
                            state_reg <= ST_DONE;
                        end else if (jlim_reg == '0) begin
                            cmd_reg   <= mul_cmd(64'(amax), {s_time_step, 16'b0}, N_DT);
                            state_reg <= ST_TMUL;
                        end else begin
                            cmd_reg   <= mul_cmd(64'(jlim_reg), {s_time_step, 16'b0}, N_DT);
                            state_reg <= ST_JMUL1;
                        end
                    end
                end
                // trapezoid: lim = amax*dt, then a = dv/dt
                ST_TMUL: begin
                    if (srsp.done) begin
                        vnew_reg  <= vsum_t;
                        dneg_reg  <= dv[35];
                        cmd_reg   <= div_cmd(mag36(dv), dt_reg);
                        state_reg <= ST_TDIV;
                    end
                end
                ST_TDIV: begin
                    if (srsp.done) begin
                        anew_reg  <= q_sat;
                        dneg_reg  <= tdiff[35];
                        cmd_reg   <= div_cmd(mag36(tdiff), dt_reg);
                        state_reg <= ST_LDIV;
                    end
                end
                // jerk mode: J*dt, then J*dt*dt
                ST_JMUL1: begin
                    if (srsp.done) begin
                        p1_reg    <= res[46:0];
                        cmd_reg   <= mul_cmd(64'(res[46:0]), {dt_reg, 16'b0}, N_DT);
                        state_reg <= ST_JMUL2;
                    end
                end
                ST_JMUL2: begin
                    if (srsp.done) begin
                        if (snap) begin
                            vnew_reg  <= vr_reg;
                            anew_reg  <= '0;
                            dneg_reg  <= ndiff[35];
                            cmd_reg   <= div_cmd(mag36(ndiff), dt_reg);
                            state_reg <= ST_LDIV;
                        end else begin
                            cmd_reg   <= mul_cmd(64'(amag_now), {dt_reg, 16'b0}, N_DT);
                            state_reg <= ST_CMUL;
                        end
                    end
                end
                ST_CMUL: begin
                    if (srsp.done) begin
                        cneg_reg  <= cval[35];
                        cmag_reg  <= mag36(cval);
                        cmd_reg   <= mul_cmd(64'(xval), {xval, 2'b00}, N_X);
                        state_reg <= ST_XMUL;
                    end
                end
                ST_XMUL: begin
                    if (srsp.done) begin
                        x2_reg    <= res[59:0];
                        cmd_reg   <= mul_cmd(64'(cmag_reg), {jlim_reg, 1'b0}, N_J);
                        state_reg <= ST_PMUL;
                    end
                end
                ST_PMUL: begin
                    if (srsp.done) begin
                        if (ovf) begin
                            dneg_reg  <= jdiff[35];
                            cmd_reg   <= div_cmd(mag36(jdiff), dt_reg);
                            state_reg <= ST_JDIV;
                        end else begin
                            cmd_reg   <= sqrt_cmd(rad);
                            state_reg <= ST_SQRT;
                        end
                    end
                end
                ST_SQRT: begin
                    if (srsp.done) begin
                        dneg_reg  <= jdiff[35];
                        cmd_reg   <= div_cmd(mag36(jdiff), dt_reg);
                        state_reg <= ST_JDIV;
                    end
                end
                ST_JDIV: begin
                    if (srsp.done) begin
                        jneg_reg  <= dneg_reg;
                        cmd_reg   <= mul_cmd(64'(jm), {dt_reg, 16'b0}, N_DT);
                        state_reg <= ST_AMUL;
                    end
                end
                ST_AMUL: begin
                    if (srsp.done) begin
                        anew_reg  <= a1_sat;
                        sneg_reg  <= asum[35];
                        cmd_reg   <= mul_cmd(64'(mag36(asum)), {dt_reg, 16'b0}, N_DT);
                        state_reg <= ST_VMUL;
                    end
                end
                ST_VMUL: begin
                    if (srsp.done) begin
                        vnew_reg  <= vnext_t;
                        dneg_reg  <= ldiff[35];
                        cmd_reg   <= div_cmd(mag36(ldiff), dt_reg);
                        state_reg <= ST_LDIV;
                    end
                end
                // jerk of the step, then commit
                ST_LDIV: begin
                    if (srsp.done) begin
                        vel_reg   <= vnew_reg;
                        acc_reg   <= anew_reg;
                        jrk_reg   <= q_sat;
                        state_reg <= ST_DONE;
                    end
                end
                ST_DONE: begin
                    if (!m_valid_reg || m_ready) begin
                        m_vel_reg   <= vel_reg;
                        m_acc_reg   <= acc_reg;
                        m_jrk_reg   <= jrk_reg;
                        m_valid_reg <= 1'b1;
                        state_reg   <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign pready         = 1'b1;
    assign s_ready        = (state_reg == ST_IDLE);
    assign m_valid        = m_valid_reg;
    assign m_velocity     = m_vel_reg;
    assign m_acceleration = m_acc_reg;
    assign m_jerk         = m_jrk_reg;

endmodule

`default_nettype wire

>>> src/jlvf_serial.sv
`default_nettype none

// one-bit-per-step multiply, one-bit divide, two-bit square root
module jlvf_serial (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire jlvf_pkg::serial_cmd_t cmd,
    output jlvf_pkg::serial_rsp_t      rsp
);

    localparam int RW = 35;

    logic                        busy_reg;
    logic                        done_reg;
    logic [jlvf_pkg::CW-1:0]     cnt_reg;
    jlvf_pkg::serial_op_t        op_reg;
    logic [jlvf_pkg::AW-1:0]     a_reg;
    logic [jlvf_pkg::BW-1:0]     b_reg;
    logic [jlvf_pkg::PW-1:0]     acc_reg;
    logic [RW-1:0]               rem_reg;

    logic [jlvf_pkg::PW-1:0]     mul_acc;
    logic [16:0]                 div_r;
    logic                        div_ge;
    logic [16:0]                 div_rem;
    logic [RW-1:0]               sq_r;
    logic [RW-1:0]               sq_t;
    logic                        sq_ge;
    logic [RW-1:0]               sq_rem;

    always_comb begin
        mul_acc = {acc_reg[jlvf_pkg::PW-2:0], 1'b0}
                + (b_reg[jlvf_pkg::BW-1] ? jlvf_pkg::PW'(a_reg) : '0);
        div_r   = {rem_reg[15:0], a_reg[jlvf_pkg::AW-1]};
        div_ge  = div_r >= {1'b0, b_reg[15:0]};
        div_rem = div_ge ? div_r - {1'b0, b_reg[15:0]} : div_r;
        sq_r    = {rem_reg[RW-3:0], a_reg[jlvf_pkg::AW-1:jlvf_pkg::AW-2]};
        sq_t    = {1'b0, acc_reg[31:0], 2'b01};
        sq_ge   = sq_r >= sq_t;
        sq_rem  = sq_ge ? sq_r - sq_t : sq_r;
    end

    // control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (cmd.start) begin
                busy_reg <= 1'b1;
            end else if (busy_reg && cnt_reg == jlvf_pkg::CW'(1)) begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    // datapath
    always_ff @(posedge aclk) begin
        if (cmd.start) begin
            op_reg  <= cmd.op;
            a_reg   <= cmd.opa;
            b_reg   <= cmd.opb;
            cnt_reg <= cmd.nbits;
            acc_reg <= '0;
            rem_reg <= '0;
        end else if (busy_reg) begin
            cnt_reg <= cnt_reg - jlvf_pkg::CW'(1);
            case (op_reg)
                jlvf_pkg::OP_MUL: begin
                    acc_reg <= mul_acc;
                    b_reg   <= {b_reg[jlvf_pkg::BW-2:0], 1'b0};
                end
                jlvf_pkg::OP_DIV: begin
                    rem_reg <= RW'(div_rem[15:0]);
                    acc_reg <= {acc_reg[jlvf_pkg::PW-2:0], div_ge};
                    a_reg   <= {a_reg[jlvf_pkg::AW-2:0], 1'b0};
                end
                jlvf_pkg::OP_SQRT: begin
                    rem_reg <= sq_rem;
                    acc_reg <= {acc_reg[jlvf_pkg::PW-2:0], sq_ge};
                    a_reg   <= {a_reg[jlvf_pkg::AW-3:0], 2'b00};
                end
                default: begin
                    acc_reg <= acc_reg;
                end
            endcase
        end
    end

    assign rsp.done = done_reg;
    assign rsp.res  = acc_reg;

endmodule

`default_nettype wire

>>> src/jlvf_checker.sv
`default_nettype none

module jlvf_assertions (
    input wire logic               aclk,
    input wire logic               aresetn,
    input wire logic               s_valid,
    input wire logic               s_ready,
    input wire logic               m_valid,
    input wire logic               m_ready,
    input wire logic signed [31:0] m_velocity,
    input wire logic signed [31:0] m_acceleration,
    input wire logic signed [31:0] m_jerk
);

    // stalled result holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_velocity)
            && $stable(m_acceleration) && $stable(m_jerk))
        else $error("stalled result changed");

    // reset leaves no result and an idle input side
    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_valid && s_ready)
        else $error("bad state after reset");

    // one step at a time
    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input taken while busy");

    // a new result only appears while a step is in flight
    a_result: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(!s_ready))
        else $error("result without a step");

endmodule

bind jerk_limited_velocity_filter jlvf_assertions u_jlvf_assertions (
    .aclk           (aclk),
    .aresetn        (aresetn),
    .s_valid        (s_valid),
    .s_ready        (s_ready),
    .m_valid        (m_valid),
    .m_ready        (m_ready),
    .m_velocity     (m_velocity),
    .m_acceleration (m_acceleration),
    .m_jerk         (m_jerk)
);

`default_nettype wire

>>> bench/jlvf_checker.sv
module jlvf_checker (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_we,
    input  logic [1:0]         cfg_idx,
    input  logic [31:0]        cfg_val,
    input  logic               s_valid,
    input  logic               s_ready,
    input  logic               s_mode,
    input  logic signed [31:0] s_target_velocity,
    input  logic [15:0]        s_time_step,
    input  logic signed [31:0] s_load_velocity,
    input  logic signed [31:0] s_load_accel,
    input  logic               m_valid,
    input  logic               m_ready,
    input  logic signed [31:0] m_velocity,
    input  logic signed [31:0] m_acceleration,
    input  logic signed [31:0] m_jerk,
    output int                 fail_count,
    output int                 pending
);

    typedef struct packed {
        logic signed [31:0] vel;
        logic signed [31:0] acc;
        logic signed [31:0] jrk;
    } motion_t;

    localparam longint QMAX = 64'sd2147483647;
    localparam longint QMIN = -64'sd2147483648;
    localparam longint ACCEL_CAP = 64'sd1 << 33;

    longint vmin, vmax, alim, jlim;
    longint vel_q, acc_q, jrk_q;
    motion_t expected_motion[$];

    function automatic longint sat32(longint x);
        return x > QMAX ? QMAX : (x < QMIN ? QMIN : x);
    endfunction

    function automatic longint clip(longint x, longint lo, longint hi);
        if (x < lo) x = lo;
        if (x > hi) x = hi;
        return x;
    endfunction

    // arithmetic shift rounds toward minus infinity
    function automatic longint floor_shr(longint x, int s);
        return x >>> s;
    endfunction

    function automatic longint iabs(longint x);
        return x < 0 ? -x : x;
    endfunction

    // signed divide by the time step, truncating
    function automatic longint rate_of(longint x, longint dt);
        return sat32((x * 65536) / dt);
    endfunction

    function automatic longint unsigned floor_root(longint unsigned n);
        longint unsigned r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > n) b >>= 2;
        while (b != 0) begin
            if (n >= r + b) begin
                n -= r + b;
                r = (r >> 1) + b;
            end else begin
                r >>= 1;
            end
            b >>= 2;
        end
        return r;
    endfunction

    task automatic step_motion(longint tgt, longint dt);
        longint vr, amax, aprev, lim, dv, jd, c, astar, jerk, a1;
        longint unsigned jj, jdd, cc, xx, x2, rlim;
        aprev = acc_q;
        if (dt == 0) return;
        vr = tgt;
        if (vr < vmin) vr = vmin;
        if (vr > vmax) vr = vmax;
        amax = (alim == 0) ? 1 : alim;
        if (jlim == 0) begin
            // trapezoid: velocity change limited to accel*dt
            lim = (amax * dt) >>> 16;
            dv = clip(vr - vel_q, -lim, lim);
            vel_q = sat32(vel_q + dv);
            acc_q = rate_of(dv, dt);
            jrk_q = rate_of(acc_q - aprev, dt);
            return;
        end
        jj = jlim;
        jd = longint'((jj * dt) >> 16);
        jdd = (jj * dt * dt) >> 32;
        if (longint'(iabs(vr - vel_q)) <= jdd && iabs(acc_q) <= jd) begin
            vel_q = vr;
            acc_q = 0;
            jrk_q = rate_of(-aprev, dt);
            return;
        end
        c = vr - vel_q - floor_shr(acc_q * dt, 17);
        cc = iabs(c);
        xx = (jj * dt) >> 17;
        x2 = xx * xx;
        rlim = (64'hFFFF_FFFF_FFFF_FFFF - x2) / 2;
        if (cc != 0 && jj > rlim / cc) astar = ACCEL_CAP;
        else astar = longint'(floor_root(x2 + 2 * cc * jj) - xx);
        if (astar > ACCEL_CAP) astar = ACCEL_CAP;
        if (c < 0) astar = -astar;
        jerk = clip(((astar - acc_q) * 65536) / dt, -longint'(jj), longint'(jj));
        a1 = acc_q + floor_shr(jerk * dt, 16);
        a1 = clip(a1, -amax, amax);
        a1 = clip(a1, acc_q - jd, acc_q + jd);
        a1 = sat32(a1);
        vel_q = sat32(vel_q + floor_shr((acc_q + a1) * dt, 17));
        acc_q = a1;
        jrk_q = rate_of(acc_q - aprev, dt);
    endtask

    always_comb pending = expected_motion.size();

    always @(posedge aclk) begin
        motion_t got, want;
        if (!aresetn) begin
            vmin <= -65536;
            vmax <= 65536;
            alim <= 65536;
            jlim <= 65536;
            vel_q = 0;
            acc_q = 0;
            jrk_q = 0;
            expected_motion.delete();
            fail_count <= 0;
        end else begin
            if (cfg_we) begin
                case (cfg_idx)
                    jlvf_pkg::REG_VMIN: vmin <= longint'($signed(cfg_val));
                    jlvf_pkg::REG_VMAX: vmax <= longint'($signed(cfg_val));
                    jlvf_pkg::REG_ALIM: alim <= longint'(cfg_val[30:0]);
                    jlvf_pkg::REG_JLIM: jlim <= longint'(cfg_val[30:0]);
                    default: ;
                endcase
            end
            if (s_valid && s_ready) begin
                if (s_mode) begin
                    vel_q = s_load_velocity;
                    acc_q = s_load_accel;
                    jrk_q = 0;
                end else begin
                    step_motion(longint'(s_target_velocity), longint'(s_time_step));
                end
                want.vel = vel_q[31:0];
                want.acc = acc_q[31:0];
                want.jrk = jrk_q[31:0];
                expected_motion.push_back(want);
            end
            if (m_valid && m_ready) begin
                got = '{m_velocity, m_acceleration, m_jerk};
                if (expected_motion.size() == 0) begin
                    $display("%0t: unexpected result transfer %h", $time, got);
                    fail_count <= fail_count + 1;
                end else begin
                    want = expected_motion.pop_front();
                    if (got !== want) begin
                        $display("%0t: mismatch expected v=%0d a=%0d j=%0d actual v=%0d a=%0d j=%0d",
                                 $time, want.vel, want.acc, want.jrk,
                                 got.vel, got.acc, got.jrk);
                        fail_count <= fail_count + 1;
                    end
                end
            end
        end
    end
endmodule

>>> bench/jerk_limited_velocity_filter_tb.sv
module jerk_limited_velocity_filter_tb;

    logic               aclk = 0;
    logic               aresetn = 0;
    logic               psel = 0, penable = 0, pwrite = 0;
    logic [3:0]         paddr = 0;
    logic [31:0]        pwdata = 0;
    logic [31:0]        prdata;
    logic               pready;
    logic               s_valid = 0;
    logic               s_ready;
    logic               s_mode = 0;
    logic signed [31:0] s_target_velocity = 0;
    logic [15:0]        s_time_step = 0;
    logic signed [31:0] s_load_velocity = 0;
    logic signed [31:0] s_load_accel = 0;
    logic               m_valid;
    logic               m_ready = 0;
    logic signed [31:0] m_velocity, m_acceleration, m_jerk;
    int                 fail_count, pending;

    // receiver behavior controls
    bit                 no_idle = 0;
    bit                 hold_off = 0;
    int                 idle_cycles = 0;

    always begin
        #5 aclk = 1;
        #5 aclk = 0;
    end

    jerk_limited_velocity_filter uut (.*);

    jlvf_checker checker_i (
        .aclk, .aresetn,
        .cfg_we(psel && penable && pwrite && pready),
        .cfg_idx(paddr[3:2]), .cfg_val(pwdata),
        .s_valid, .s_ready, .s_mode, .s_target_velocity, .s_time_step,
        .s_load_velocity, .s_load_accel,
        .m_valid, .m_ready, .m_velocity, .m_acceleration, .m_jerk,
        .fail_count, .pending
    );

    // receiver: random stalls, one long hold-off, and a no-idle stretch
    always @(negedge aclk) begin
        if (hold_off) m_ready <= 0;
        else if (no_idle) m_ready <= 1;
        else m_ready <= ($urandom_range(99) >= 17);
    end

    // watchdog on accepted transfers
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || !aresetn) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles > 20000) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    task automatic reg_write(logic [1:0] idx, logic [31:0] val);
        @(negedge aclk);
        psel <= 1; penable <= 0; pwrite <= 1;
        paddr <= {idx, 2'b00}; pwdata <= val;
        @(negedge aclk);
        penable <= 1;
        @(negedge aclk);
        psel <= 0; penable <= 0; pwrite <= 0;
    endtask

    task automatic set_limits(logic [31:0] lo, logic [31:0] hi, logic [31:0] al,
                              logic [31:0] jl);
        reg_write(jlvf_pkg::REG_VMIN, lo);
        reg_write(jlvf_pkg::REG_VMAX, hi);
        reg_write(jlvf_pkg::REG_ALIM, al);
        reg_write(jlvf_pkg::REG_JLIM, jl);
    endtask

    // wait for all results, then let the block settle before reconfiguring
    task automatic drain();
        while (pending != 0) @(negedge aclk);
        repeat (400) @(negedge aclk);
    endtask

    // one input transfer, with an optional random gap first
    task automatic send_step(bit mode, logic [31:0] tgt, logic [15:0] dt,
                             logic [31:0] lv, logic [31:0] la, bit gaps);
        @(negedge aclk);
        if (gaps) while ($urandom_range(99) < 17) @(negedge aclk);
        s_valid <= 1;
        s_mode <= mode;
        s_target_velocity <= tgt;
        s_time_step <= dt;
        s_load_velocity <= lv;
        s_load_accel <= la;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        @(negedge aclk);
        s_valid <= 0;
    endtask

    function automatic logic [31:0] rand_word();
        case ($urandom_range(3))
            0: return $urandom;
            1: return $signed($urandom_range(262143)) - 131072;
            2: return $urandom_range(1) ? 32'h7fff_ffff : 32'h8000_0000;
            default: return $signed($urandom_range(8191)) - 4096;
        endcase
    endfunction

    function automatic logic [15:0] rand_dt();
        case ($urandom_range(3))
            0: return 16'($urandom);
            1: return $urandom_range(1) ? 16'hffff : 16'd1;
            default: return 16'($urandom_range(4000, 1));
        endcase
    endfunction

    // a run of steps toward a few targets, seeded by an occasional load
    task automatic random_phase(int n);
        logic [31:0] tgt;
        for (int i = 0; i < n; i++) begin
            if (i % 12 == 0) tgt = rand_word();
            if ($urandom_range(99) < 6)
                send_step(1, rand_word(), rand_dt(), rand_word(), rand_word(), !no_idle);
            else if ($urandom_range(99) < 4)
                send_step(0, rand_word(), 16'd0, rand_word(), rand_word(), !no_idle);
            else
                send_step(0, ($urandom_range(99) < 80) ? tgt : rand_word(), rand_dt(),
                          $urandom, $urandom, !no_idle);
        end
    endtask

    initial begin
        repeat (8) @(negedge aclk);
        aresetn <= 1;

        // directed: reset limits, extremes, load, hold
        send_step(1, 0, 0, 32'h7fff_ffff, 32'h8000_0000, 0);
        send_step(0, 32'h7fff_ffff, 16'hffff, 0, 0, 0);
        send_step(0, 32'h8000_0000, 16'd1, 0, 0, 0);
        send_step(0, 0, 16'd0, 32'hffff_ffff, 32'hffff_ffff, 0);
        send_step(1, 32'hffff_ffff, 16'hffff, 32'h8000_0000, 32'h7fff_ffff, 0);
        send_step(0, 32'h0000_8000, 16'h8000, 0, 0, 0);
        send_step(1, 0, 0, 0, 0, 0);
        send_step(0, 32'h10, 16'h0001, 0, 0, 0);   // small step toward a close target
        send_step(0, 32'h10, 16'h0001, 0, 0, 0);
        drain();

        // trapezoid mode with widest limits
        set_limits(32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff, 0);
        send_step(0, 32'h7fff_ffff, 16'hffff, 0, 0, 0);
        send_step(0, 32'h8000_0000, 16'hffff, 0, 0, 0);
        send_step(0, 32'h0001_0000, 16'd3, 0, 0, 0);
        drain();

        // zero acceleration limit, inverted velocity limits
        set_limits(32'h0002_0000, 32'hfffe_0000, 32'h8000_0000, 32'h7fff_ffff);
        send_step(0, 32'h7fff_ffff, 16'hffff, 0, 0, 0);
        send_step(1, 0, 0, 32'h8000_0000, 32'h7fff_ffff, 0);
        send_step(0, 32'h7fff_ffff, 16'hffff, 0, 0, 0);   // huge radicand
        drain();

        // acceleration above a lowered limit
        set_limits(32'h8000_0000, 32'h7fff_ffff, 32'h0000_4000, 32'h0000_0100);
        send_step(1, 0, 0, 0, 32'h0010_0000, 0);
        send_step(0, 32'h7000_0000, 16'h1000, 0, 0, 0);
        send_step(0, 32'h7000_0000, 16'h1000, 0, 0, 0);
        drain();

        // random phases over several limit settings
        for (int p = 0; p < 10; p++) begin
            case (p % 4)
                0: set_limits(rand_word(), rand_word(), $urandom, $urandom);
                1: set_limits(32'hfff0_0000, 32'h0010_0000, $urandom_range(1 << 20),
                              0);
                2: set_limits(32'h8000_0000, 32'h7fff_ffff, $urandom,
                              $urandom_range(1 << 22));
                default: set_limits(rand_word(), rand_word(), $urandom_range(3),
                                    $urandom_range(7));
            endcase
            if (p == 3) begin
                // receiver holds off long enough for the block to stall its input
                fork
                    begin
                        hold_off = 1;
                        repeat (1500) @(negedge aclk);
                        hold_off = 0;
                    end
                    random_phase(110);
                join
            end else if (p == 6) begin
                no_idle = 1;
                random_phase(110);
                no_idle = 0;
            end else begin
                random_phase(110);
            end
            drain();   // sender pauses until every result is back
        end

        repeat (50) @(negedge aclk);
        if (fail_count == 0 && pending == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end
endmodule
